/* hdl/arr_pkg.sv */
// shared types and constants for the aggregate ratio rank block
// no dependencies
`default_nettype none
package arr_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned REC_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned RATE_W  = 58;
  localparam int unsigned SCALE_W = 10;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;
  // one quotient bit per step over the scaled numerator
  localparam int unsigned DIV_STEPS = RATE_W;
  localparam int unsigned DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ACC,
    OP_LOAD,
    OP_DIV,
    OP_FROM_LEFT,
    OP_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;
  } cell_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SUM_W-1:0]  imp;
    logic [SUM_W-1:0]  spend;
    logic [RATE_W-1:0] rate;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/arr_cell.sv */
// one table cell: accumulate, bit-serial rate divide, neighbor exchange
// depends on arr_pkg
`default_nettype none
module arr_cell (
  input  wire logic                      clk,
  input  wire arr_pkg::cell_ctl_t        ctl,
  input  wire logic                      new_en,
  input  wire logic [arr_pkg::ID_W-1:0]  in_id,
  input  wire logic [arr_pkg::REC_W-1:0] in_imp,
  input  wire logic [arr_pkg::REC_W-1:0] in_spend,
  input  wire arr_pkg::entry_t           left_in,
  input  wire arr_pkg::entry_t           right_in,
  output arr_pkg::entry_t                ent,
  output logic                           hit
);

  logic [arr_pkg::SUM_W-1:0] rem;
  logic [arr_pkg::SUM_W:0]   imp_sum;
  logic [arr_pkg::SUM_W:0]   spend_sum;
  logic [arr_pkg::SUM_W:0]   shifted;
  logic [arr_pkg::SUM_W:0]   diff;
  logic                      ge;

  assign hit = ctl.valid && (ent.id == in_id);

  assign imp_sum   = {1'b0, ent.imp} + {{(arr_pkg::SUM_W - arr_pkg::REC_W + 1){1'b0}}, in_imp};
  assign spend_sum = {1'b0, ent.spend}
                   + {{(arr_pkg::SUM_W - arr_pkg::REC_W + 1){1'b0}}, in_spend};

  // restoring divide step, zero divisor gives all-zero quotient
  assign shifted = {rem, ent.rate[arr_pkg::RATE_W-1]};
  assign diff    = shifted - {1'b0, ent.imp};
  assign ge      = (ent.imp != '0) && (shifted >= {1'b0, ent.imp});

  always_ff @(posedge clk) begin
    case (ctl.op)
      arr_pkg::OP_ACC: begin
        if (hit) begin
          ent.imp   <= imp_sum[arr_pkg::SUM_W] ? '1 : imp_sum[arr_pkg::SUM_W-1:0];
          ent.spend <= spend_sum[arr_pkg::SUM_W] ? '1 : spend_sum[arr_pkg::SUM_W-1:0];
        end else if (new_en) begin
          ent.id    <= in_id;
          ent.imp   <= arr_pkg::SUM_W'(in_imp);
          ent.spend <= arr_pkg::SUM_W'(in_spend);
        end
      end
      arr_pkg::OP_LOAD: begin
        ent.rate <= {{(arr_pkg::RATE_W - arr_pkg::SUM_W){1'b0}}, ent.spend}
                  * arr_pkg::RATE_W'(arr_pkg::RATE_SCALE);
        rem      <= '0;
      end
      arr_pkg::OP_DIV: begin
        rem      <= ge ? diff[arr_pkg::SUM_W-1:0] : shifted[arr_pkg::SUM_W-1:0];
        ent.rate <= {ent.rate[arr_pkg::RATE_W-2:0], ge};
      end
      arr_pkg::OP_FROM_LEFT:  ent <= left_in;
      arr_pkg::OP_FROM_RIGHT: ent <= right_in;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/aggregate_ratio_rank.sv */
// top level: aggregating rate ranker built on a row of arr_cell cells
// depends on arr_pkg and arr_cell
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | item_id, impressions, spend, batch_end
//  out     | out_valid / out_ready | ranked_id, total_impressions, total_spend,
//          |                       | rate, dropped, last_rank
//
// for each accepted record every cell compares its id
// in parallel and the hit cell (or the next free cell) updates in place.
// a batch end then runs a load step, the divide steps (one quotient bit per cycle
// in every cell at once), TABLE_ENTRIES odd-even sort passes, then one result
// per cycle as out_ready allows, shifted out of cell 0 toward the left.
// input is not taken while a batch is being ranked or emitted.
// reset clears the fill count, drop flag and state; cell contents need none.
`default_nettype none
module aggregate_ratio_rank #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [arr_pkg::ID_W-1:0]   item_id,
  input  wire logic [arr_pkg::REC_W-1:0]  impressions,
  input  wire logic [arr_pkg::REC_W-1:0]  spend,
  input  wire logic                       batch_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [arr_pkg::ID_W-1:0]        ranked_id,
  output logic [arr_pkg::SUM_W-1:0]       total_impressions,
  output logic [arr_pkg::SUM_W-1:0]       total_spend,
  output logic [arr_pkg::RATE_W-1:0]      rate,
  output logic                            dropped,
  output logic                            last_rank
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_DIV, ST_SORT, ST_OUT} state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic                      overflow;
  logic [arr_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [CW-1:0]             pass;

  arr_pkg::entry_t           ents   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]  hits;
  logic [TABLE_ENTRIES-2:0]  swaps;
  logic                      any_hit;
  logic                      in_fire;
  logic                      out_fire;
  logic                      full;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign any_hit   = |hits;
  assign full      = (count == CW'(TABLE_ENTRIES));

  // results always leave from cell 0
  assign ranked_id         = ents[0].id;
  assign total_impressions = ents[0].imp;
  assign total_spend       = ents[0].spend;
  assign rate              = ents[0].rate;
  assign dropped           = overflow;
  assign last_rank         = (count == CW'(1));

  // odd-even transposition: strict compare keeps equal rates in order
  for (genvar k = 0; k < TABLE_ENTRIES - 1; k++) begin : g_pair
    assign swaps[k] = (state == ST_SORT) && (pass[0] == 1'(k % 2))
                    && (CW'(k + 1) < count) && (ents[k].rate < ents[k+1].rate);
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    arr_pkg::cell_ctl_t ctl;
    arr_pkg::entry_t    left_in;
    arr_pkg::entry_t    right_in;
    logic               take_left;
    logic               take_right;
    logic               new_en;

    if (k == 0) begin : g_first
      assign left_in   = '0;
      assign take_left = 1'b0;
    end else begin : g_mid_l
      assign left_in   = ents[k-1];
      assign take_left = swaps[k-1];
    end
    if (k == TABLE_ENTRIES - 1) begin : g_last
      assign right_in   = '0;
      assign take_right = 1'b0;
    end else begin : g_mid_r
      assign right_in   = ents[k+1];
      assign take_right = swaps[k];
    end

    assign new_en = !any_hit && (count == CW'(k));

    always_comb begin
      ctl.valid = (CW'(k) < count);
      case (state)
        ST_IDLE: ctl.op = in_fire ? arr_pkg::OP_ACC : arr_pkg::OP_HOLD;
        ST_LOAD: ctl.op = arr_pkg::OP_LOAD;
        ST_DIV:  ctl.op = arr_pkg::OP_DIV;
        ST_SORT: ctl.op = take_right ? arr_pkg::OP_FROM_RIGHT
                        : (take_left ? arr_pkg::OP_FROM_LEFT : arr_pkg::OP_HOLD);
        ST_OUT:  ctl.op = out_fire ? arr_pkg::OP_FROM_RIGHT : arr_pkg::OP_HOLD;
        default: ctl.op = arr_pkg::OP_HOLD;
      endcase
    end

    arr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_en   (new_en),
      .in_id    (item_id),
      .in_imp   (impressions),
      .in_spend (spend),
      .left_in  (left_in),
      .right_in (right_in),
      .ent      (ents[k]),
      .hit      (hits[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      div_cnt  <= '0;
      pass     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (!any_hit) begin
              if (full) overflow <= 1'b1;
              else      count    <= count + CW'(1);
            end
            if (batch_end) state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + arr_pkg::DIV_CNT_W'(1);
          if (div_cnt == arr_pkg::DIV_CNT_W'(arr_pkg::DIV_STEPS - 1)) begin
            pass  <= '0;
            state <= ST_SORT;
          end
        end
        ST_SORT: begin
          pass <= pass + CW'(1);
          if (pass == CW'(TABLE_ENTRIES - 1)) begin
            if (count == '0) begin
              overflow <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              overflow <= 1'b0;
              state    <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/arr_checker.sv */
// port-level checks for aggregate_ratio_rank, attached by bind
// depends on arr_pkg
`default_nettype none
module arr_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      batch_end,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [arr_pkg::ID_W-1:0]  ranked_id,
  input wire logic                      last_rank
);

  // input and output never open together
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output both open");

  // a batch end transaction closes the input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && batch_end) |=> !in_ready)
    else $error("input still open after batch end");

  // the final ranked result ends the run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_rank) |=> !out_valid)
    else $error("result after last rank");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ranked_id)))
    else $error("stalled result changed");

endmodule

bind aggregate_ratio_rank arr_checker u_arr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .batch_end (batch_end),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ranked_id (ranked_id),
  .last_rank (last_rank)
);
`default_nettype wire
